// ===== design/assert_macros.svh =====
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== design/sdds_pkg.sv =====
package sdds_pkg;
  localparam int HIST_DEPTH = 128;
  localparam int HIST_AW    = 7;
  localparam int DESC_BYTES = 32;
  localparam int DESC_W     = 256;
  localparam int COST_W     = 13;
  localparam int DISP_W     = 7;
  localparam int COL_W      = 10;
  localparam logic [DISP_W-1:0] MAXD_RESET = 7'd112;
  localparam logic [0:0] REG_MAX_DISP = 1'b0;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic              rv;
    logic [DISP_W-1:0] d;
  } tag_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT} state_t;
endpackage

// ===== design/stereo_descriptor_disparity_search.sv =====
// Disparity search over one rectified row. Each input word is one pixel;
// its right descriptor goes into a 128-entry history at column mod 128.
// A matched pixel (left flag set, column above max_disparity) reads the
// history once per candidate, from max_disparity down to 0, one read a
// cycle, and the candidates stream through a chain of 32 byte cells that
// accumulate the absolute-difference cost. The history read and each cell
// are registered, and the best cost is compared at the chain end. A new
// pixel is accepted only in the idle state, once a matched pixel's scan has
// left the chain, and only while the output word is empty or being taken;
// an unmatched pixel is done in the idle state with disparity 0.
module stereo_descriptor_disparity_search (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // column, left_word_0..3, right_word_0..3, zero pad
  input  logic [527:0] in_tdata,
  // left_valid, right_valid
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // disparity, out_column, zero pad
  output logic [23:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic         cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import sdds_pkg::*;

  state_t state_r, state_nxt;
  logic [DISP_W-1:0] maxd_r;
  logic [COL_W-1:0]  col_r;
  logic [DESC_W-1:0] left_r;
  logic [DISP_W-1:0] cnt_r, cnt_nxt;
  tag_t              iss_r, iss_nxt;
  logic              have_r, have_nxt;
  logic [COST_W-1:0] best_r, best_nxt;
  logic [DISP_W-1:0] bestd_r, bestd_nxt;
  logic              ov_r, ov_nxt;
  logic [DISP_W-1:0] odisp_r, odisp_nxt;
  logic [COL_W-1:0]  ocol_r, ocol_nxt;

  logic              acc;
  logic              match;
  logic [COL_W-1:0]  in_col;
  logic [DESC_W:0]   rd_data;
  logic [HIST_AW-1:0] rd_addr;
  logic [COST_W-1:0] cost;

  tag_t              ctag  [DESC_BYTES+1];
  logic [DESC_W-1:0] cright[DESC_BYTES+1];
  logic [COST_W-1:0] csum  [DESC_BYTES+1];

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-DISP_W){1'b0}}, maxd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxd_r <= MAXD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_MAX_DISP)) begin
      maxd_r <= cfg_pwdata[DISP_W-1:0];
    end
  end

  assign in_col    = in_tdata[COL_W-1:0];
  assign in_tready = (state_r == S_IDLE) && (!ov_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign match     = in_tuser[0] && (in_col > {{(COL_W-DISP_W){1'b0}}, maxd_r});
  assign rd_addr   = col_r[HIST_AW-1:0] - cnt_r;

  sdds_hist u_hist (
    .clk       (clk),
    .wr_en     (acc),
    .wr_addr   (in_col[HIST_AW-1:0]),
    .wr_data   ({in_tuser[1], in_tdata[521:266]}),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  assign ctag[0]   = iss_r;
  assign cright[0] = rd_data[DESC_W-1:0];
  assign csum[0]   = '0;

  for (genvar k = 0; k < DESC_BYTES; k++) begin : g_cell
    tag_t tag_in_k;
    always_comb begin
      tag_in_k = ctag[k];
      if (k == 0) begin
        tag_in_k.rv = rd_data[DESC_W];
      end
    end
    sdds_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lbyte    (left_r[8*k +: 8]),
      .rbyte    (cright[k][8*k +: 8]),
      .tag_in   (tag_in_k),
      .right_in (cright[k]),
      .sum_in   (csum[k]),
      .tag_r    (ctag[k+1]),
      .right_r  (cright[k+1]),
      .sum_r    (csum[k+1])
    );
  end

  assign cost = ctag[DESC_BYTES].rv ? csum[DESC_BYTES] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= '0;
      ov_r    <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      ov_r    <= ov_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    best_r  <= best_nxt;
    bestd_r <= bestd_nxt;
    odisp_r <= odisp_nxt;
    ocol_r  <= ocol_nxt;
    if (acc) begin
      col_r  <= in_col;
      left_r <= in_tdata[265:10];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    iss_nxt   = '0;
    have_nxt  = have_r;
    best_nxt  = best_r;
    bestd_nxt = bestd_r;
    ov_nxt    = ov_r && !out_tready;
    odisp_nxt = odisp_r;
    ocol_nxt  = ocol_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (match) begin
            state_nxt = S_SCAN;
            cnt_nxt   = maxd_r;
            have_nxt  = 1'b0;
          end else begin
            ov_nxt    = 1'b1;
            odisp_nxt = '0;
            ocol_nxt  = in_col;
          end
        end
      end
      S_SCAN: begin
        iss_nxt.vld  = 1'b1;
        iss_nxt.last = (cnt_r == '0);
        iss_nxt.d    = cnt_r;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (ctag[DESC_BYTES].vld) begin
      if (!have_r || (cost < best_r)) begin
        have_nxt  = 1'b1;
        best_nxt  = cost;
        bestd_nxt = ctag[DESC_BYTES].d;
      end
      if (ctag[DESC_BYTES].last) begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        odisp_nxt = (best_nxt == '0) ? '0 : bestd_nxt;
        ocol_nxt  = col_r;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, ocol_r, odisp_r};
endmodule

// ===== design/sdds_hist.sv =====
module sdds_hist (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [sdds_pkg::HIST_AW-1:0]  wr_addr,
  input  logic [sdds_pkg::DESC_W:0]     wr_data,
  input  logic [sdds_pkg::HIST_AW-1:0]  rd_addr,
  output logic [sdds_pkg::DESC_W:0]     rd_data_r
);
  import sdds_pkg::*;

  logic [DESC_W:0] mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end
endmodule

// ===== design/sdds_cell.sv =====
// One byte lane of the cost chain: adds |left - right| for its byte and
// hands the partial sum, tag and right descriptor to the next cell.
module sdds_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  lbyte,
  input  logic [7:0]                  rbyte,
  input  sdds_pkg::tag_t              tag_in,
  input  logic [sdds_pkg::DESC_W-1:0] right_in,
  input  logic [sdds_pkg::COST_W-1:0] sum_in,
  output sdds_pkg::tag_t              tag_r,
  output logic [sdds_pkg::DESC_W-1:0] right_r,
  output logic [sdds_pkg::COST_W-1:0] sum_r
);
  import sdds_pkg::*;

  logic [7:0] diff;

  assign diff = (lbyte > rbyte) ? (lbyte - rbyte) : (rbyte - lbyte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    right_r <= right_in;
    sum_r   <= sum_in + {{(COST_W-8){1'b0}}, diff};
  end
endmodule

// ===== design/sdds_checker.sv =====
`include "assert_macros.svh"

module sdds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_IMP(a_no_take_when_full, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[23:17] == 7'd0)
  `ASSERT_IMP(a_disp_below_col, clk, rst_n, out_tvalid && (out_tdata[6:0] != 7'd0),
    out_tdata[16:7] > {3'd0, out_tdata[6:0]})
endmodule

bind stereo_descriptor_disparity_search sdds_checker u_sdds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/stereo_descriptor_disparity_search_tb.sv =====
`timescale 1ns / 100ps

module stereo_descriptor_disparity_search_tb;
  import sdds_pkg::*;

  localparam int DEPTH = 128;
  localparam int WIDTH_LIMIT = 1024;

  typedef struct packed {
    logic [6:0] disparity;
    logic [9:0] column;
  } disp_word_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // column, left_word_0..3, right_word_0..3, zero pad
  logic [527:0] in_tdata;
  // left_valid, right_valid
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  // disparity, out_column, zero pad
  logic [23:0]  out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic         cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  stereo_descriptor_disparity_search dut (.*);

  // predictor state
  logic [255:0] hist_desc [DEPTH];
  logic         hist_ok [DEPTH];
  logic [6:0]   cur_maxd;
  disp_word_t   expected_q[$];
  int           error_count;
  int           sent_count;
  int           rx_count;
  int           next_col;
  int           out_wait = 0;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int desc_sad(logic [255:0] a, logic [255:0] b);
    int sum;
    int x;
    int y;
    sum = 0;
    for (int k = 0; k < 32; k++) begin
      x = a[8*k +: 8];
      y = b[8*k +: 8];
      sum += (x > y) ? x - y : y - x;
    end
    return sum;
  endfunction

  function automatic disp_word_t predict_disparity(logic [9:0] col, logic [255:0] ldesc,
                                                   logic [255:0] rdesc, logic lv, logic rv);
    disp_word_t r;
    int slot;
    int maxd;
    int best_cost;
    int best_d;
    int cost;
    int d;
    slot = col % DEPTH;
    maxd = cur_maxd;
    hist_desc[slot] = rdesc;
    hist_ok[slot] = rv;
    r.column = col;
    r.disparity = '0;
    if (lv && col > maxd && col < WIDTH_LIMIT) begin
      best_cost = 0;
      best_d = 0;
      for (int i = 0; i <= maxd; i++) begin
        d = maxd - i;
        slot = (col - d) % DEPTH;
        cost = hist_ok[slot] ? desc_sad(ldesc, hist_desc[slot]) : 0;
        if (i == 0 || cost < best_cost) begin
          best_cost = cost;
          best_d = d;
        end
      end
      r.disparity = (best_cost == 0) ? 7'd0 : 7'(best_d);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("error at result %0d: %s got %0d want %0d", rx_count, what, got, want);
    error_count++;
  endtask

  task automatic send_pixel(logic [9:0] col, logic [255:0] ldesc, logic [255:0] rdesc,
                            logic lv, logic rv);
    int gap;
    disp_word_t item;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item = predict_disparity(col, ldesc, rdesc, lv, rv);
    expected_q = {expected_q, item};
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, rdesc, ldesc, col};
    in_tuser <= {rv, lv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    disp_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word, column", out_tdata[16:7], 0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[6:0] !== want.disparity)
          report_mismatch("disparity", out_tdata[6:0], want.disparity);
        if (out_tdata[16:7] !== want.column)
          report_mismatch("column", out_tdata[16:7], want.column);
      end
      rx_count++;
      out_wait = $urandom_range(0, 4);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_tready <= (out_wait == 0);
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_max_disparity(logic [6:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_MAX_DISP;
    cfg_pwdata <= {25'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cur_maxd = value;
  endtask

  function automatic logic [255:0] rand_desc();
    logic [255:0] v;
    for (int k = 0; k < 8; k++) v[32*k +: 32] = $urandom;
    return v;
  endfunction

  // nearby-valued descriptor so cost minima land on interior candidates
  function automatic logic [255:0] near_desc(logic [255:0] base, int spread);
    logic [255:0] v;
    int b;
    for (int k = 0; k < 32; k++) begin
      b = int'(base[8*k +: 8]) + $urandom_range(0, spread) - spread / 2;
      v[8*k +: 8] = (b < 0) ? 8'd0 : (b > 255) ? 8'd255 : 8'(b);
    end
    return v;
  endfunction

  // one row from column 0; every history slot gets written before it is read
  task automatic send_row(int n, int mode);
    logic [255:0] base;
    logic [255:0] l;
    logic [255:0] r;
    logic lv;
    logic rv;
    base = rand_desc();
    for (int c = 0; c < n; c++) begin
      lv = ($urandom_range(0, 5) != 0);
      rv = ($urandom_range(0, 5) != 0);
      case (mode)
        0: begin
          l = near_desc(base, 40);
          r = near_desc(base, 40);
        end
        1: begin
          l = rand_desc();
          r = rand_desc();
        end
        default: begin
          l = base;
          r = ($urandom_range(0, 3) == 0) ? near_desc(base, 6) : base;
        end
      endcase
      send_pixel(10'(c), l, r, lv, rv);
    end
  endtask

  task automatic test_directed();
    write_max_disparity(7'd1);
    // column 0 and 1 never matched; extremes of descriptor bytes
    send_pixel(10'd0, '0, '1, 1'b1, 1'b1);
    send_pixel(10'd1, '1, '0, 1'b1, 1'b1);
    send_pixel(10'd2, '1, '1, 1'b1, 1'b1);  // zero cost at d=0 beats nothing
    send_pixel(10'd3, '0, '1, 1'b1, 1'b0);  // invalid right gives zero cost
    send_pixel(10'd4, '1, '0, 1'b0, 1'b1);  // left invalid
    send_pixel(10'd5, '1, '1, 1'b1, 1'b1);
    send_pixel(10'd6, '0, '0, 1'b1, 1'b1);
    send_pixel(10'd7, {32{8'h80}}, {32{8'h7f}}, 1'b1, 1'b1);
    drain();
    write_max_disparity(7'd127);
    send_row(140, 2);
    // gap in columns up to the row end
    send_pixel(10'd1023, '1, '0, 1'b1, 1'b1);
    send_pixel(10'd1000, '0, '1, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_random_rows();
    logic [6:0] settings [5] = '{7'd112, 7'd1, 7'd4, 7'd31, 7'd127};
    int n;
    for (int s = 0; s < 5; s++) begin
      write_max_disparity(settings[s]);
      repeat (2) begin
        n = (settings[s] > 40) ? $urandom_range(settings[s] + 1, 150) : $urandom_range(30, 110);
        send_row(n, $urandom_range(0, 2));
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 1'b0;
    cfg_pwdata = '0;
    cur_maxd = MAXD_RESET;
    error_count = 0;
    sent_count = 0;
    rx_count = 0;
    for (int i = 0; i < DEPTH; i++) begin
      hist_desc[i] = '0;
      hist_ok[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_rows();
    if (error_count == 0) begin
      $display("stereo_descriptor_disparity_search: match");
    end else begin
      $display("stereo_descriptor_disparity_search: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("stereo_descriptor_disparity_search: mismatch");
    $finish;
  end

endmodule
